[hdl/safl_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted address floor lookup package
// Shared sizes, action codes, state type and structs for the sorted table.
// ----------------------------------------------------------------------------
package safl_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int ADDR_W        = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int IDXO_W        = 8;
  localparam int GRP_SIZE      = 16;
  localparam int NUM_GRP       = (TABLE_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2
  } safl_act_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RED1,
    S_RED2
  } safl_state_e;

  // command broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              clr;
    logic              cmp;
    logic [ADDR_W-1:0] key;
  } safl_cmd_t;

  // link from a cell to its right neighbor
  typedef struct packed {
    logic              occ;
    logic              gt;
    logic [ADDR_W-1:0] value;
  } safl_link_t;

  // floor hit from a cell to the reducer
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] value;
  } safl_hit_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [ADDR_W-1:0] value;
  } safl_res_t;

endpackage

[hdl/safl_if.sv]
// ----------------------------------------------------------------------------
// Sorted address floor lookup channels
// Valid/ready interfaces for the request and the result beats.
// ----------------------------------------------------------------------------
interface safl_in_if;
  import safl_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [ADDR_W-1:0] address;

  modport source (output valid, action, address, input ready);
  modport sink   (input valid, action, address, output ready);
endinterface

interface safl_out_if;
  import safl_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [IDXO_W-1:0] entry_index;
  logic [ADDR_W-1:0] entry_address;
  logic              status;

  modport source (output valid, found, entry_index, entry_address, status, input ready);
  modport sink   (input valid, found, entry_index, entry_address, status, output ready);
endinterface

[hdl/safl_cell.sv]
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one entry; shifts right on insert and flags the floor on a query.
// ----------------------------------------------------------------------------
module safl_cell
  import safl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  safl_cmd_t  cmd_i,
  input  safl_link_t left_i,
  input  logic       right_le_i,
  output safl_link_t link_o,
  output logic       le_o,
  output safl_hit_t  hit_o
);

  logic              occ_q, occ_d;
  logic              le_q, le_d;
  logic [ADDR_W-1:0] val_q, val_d;
  logic              gt;

  assign gt     = !occ_q || (val_q > cmd_i.key);
  assign link_o = '{occ: occ_q, gt: gt, value: val_q};
  assign le_o   = le_q;
  assign hit_o  = '{hit: le_q && !right_le_i, value: val_q};

  always_comb begin
    occ_d = occ_q;
    val_d = val_q;
    le_d  = le_q;
    if (cmd_i.clr) begin
      occ_d = 1'b0;
    end else if (cmd_i.ins && gt) begin
      if (left_i.gt) begin
        occ_d = left_i.occ;
        val_d = left_i.value;
      end else begin
        occ_d = 1'b1;
        val_d = cmd_i.key;
      end
    end
    if (cmd_i.cmp) begin
      le_d = !gt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      le_q  <= 1'b0;
    end else begin
      occ_q <= occ_d;
      le_q  <= le_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

[hdl/safl_reduce.sv]
// ----------------------------------------------------------------------------
// Floor hit reducer
// Collects the single hit cell over a registered group stage and a final OR.
// ----------------------------------------------------------------------------
module safl_reduce
  import safl_pkg::*;
(
  input  logic      clk_i,
  input  safl_hit_t hits_i [TABLE_ENTRIES],
  output safl_res_t res_o
);

  logic              grp_hit_q [NUM_GRP];
  logic [IDX_W-1:0]  grp_idx_q [NUM_GRP];
  logic [ADDR_W-1:0] grp_val_q [NUM_GRP];
  logic              grp_hit_d [NUM_GRP];
  logic [IDX_W-1:0]  grp_idx_d [NUM_GRP];
  logic [ADDR_W-1:0] grp_val_d [NUM_GRP];

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      grp_val_d[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < TABLE_ENTRIES) begin
          if (hits_i[g * GRP_SIZE + k].hit) begin
            grp_hit_d[g] = 1'b1;
            grp_idx_d[g] = grp_idx_d[g] | IDX_W'(g * GRP_SIZE + k);
            grp_val_d[g] = grp_val_d[g] | hits_i[g * GRP_SIZE + k].value;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_hit_q <= grp_hit_d;
    grp_idx_q <= grp_idx_d;
    grp_val_q <= grp_val_d;
  end

  always_comb begin
    res_o = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      if (grp_hit_q[g]) begin
        res_o.found = 1'b1;
        res_o.index = res_o.index | grp_idx_q[g];
        res_o.value = res_o.value | grp_val_q[g];
      end
    end
  end

endmodule

[hdl/sorted_address_floor_lookup.sv]
// ----------------------------------------------------------------------------
// Sorted address floor lookup
// Sorted start-address table with floor search, built as a row of cells.
// ----------------------------------------------------------------------------
// The table is a row of TABLE_ENTRIES cells kept in ascending order. A clear
// or insert beat updates every cell and loads its result into the output
// register together, so those beats run one per cycle while results are
// taken. A query beat runs in order: the cells compare against the address,
// a registered stage reduces the cells in groups of 16, and a final OR of the
// groups loads the result. The input is held off during a query. A result
// waits in the output register until it is taken and holds off the input
// while it waits; the next beat can enter in the cycle the result is taken.
module sorted_address_floor_lookup
  import safl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  safl_in_if.sink    in_i,
  safl_out_if.source out_o
);

  safl_state_e state_q, state_d;
  safl_cmd_t   cmd;
  safl_link_t  links [TABLE_ENTRIES+1];
  logic        les   [TABLE_ENTRIES+1];
  safl_hit_t   hits  [TABLE_ENTRIES];
  safl_res_t   res;
  logic        accept;
  logic        full;

  logic              out_vld_q, out_vld_d;
  logic              found_q, found_d;
  logic [IDXO_W-1:0] idx_q, idx_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              status_q, status_d;
  logic [IDX_W+IDXO_W-1:0] idx_ext;

  assign links[0]            = '{occ: 1'b1, gt: 1'b0, value: '0};
  assign les[TABLE_ENTRIES]  = 1'b0;
  assign full                = links[TABLE_ENTRIES].occ;
  assign accept              = in_i.valid && in_i.ready;
  assign idx_ext             = {{IDXO_W{1'b0}}, res.index};

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    safl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .left_i     (links[i]),
      .right_le_i (les[i+1]),
      .link_o     (links[i+1]),
      .le_o       (les[i]),
      .hit_o      (hits[i])
    );
  end

  safl_reduce u_reduce (
    .clk_i  (clk_i),
    .hits_i (hits),
    .res_o  (res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && in_i.action == ACT_QUERY) begin
          state_d = S_RED1;
        end
      end
      S_RED1:  state_d = S_RED2;
      S_RED2:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == S_IDLE) && (!out_vld_q || out_o.ready);
    cmd.key    = in_i.address;
    cmd.ins    = accept && in_i.action == ACT_INSERT && !full;
    cmd.clr    = accept && in_i.action == ACT_CLEAR;
    cmd.cmp    = accept && in_i.action == ACT_QUERY;

    out_vld_d = out_vld_q && !out_o.ready;
    found_d   = found_q;
    idx_d     = idx_q;
    addr_d    = addr_q;
    status_d  = status_q;

    case (state_q)
      S_IDLE: begin
        if (accept && in_i.action != ACT_QUERY) begin
          out_vld_d = 1'b1;
          found_d   = 1'b0;
          idx_d     = '0;
          addr_d    = '0;
          status_d  = in_i.action == ACT_INSERT && full;
        end
      end
      S_RED2: begin
        out_vld_d = 1'b1;
        found_d   = res.found;
        idx_d     = idx_ext[IDXO_W-1:0];
        addr_d    = res.value;
        status_d  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    idx_q    <= idx_d;
    addr_q   <= addr_d;
    status_q <= status_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.found         = found_q;
  assign out_o.entry_index   = idx_q;
  assign out_o.entry_address = addr_q;
  assign out_o.status        = status_q;

endmodule
